// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/gffra_pkg.sv =====
// Package: types and codes of the grid first-fit rectangle allocator.
`timescale 1ns / 1ps
package gffra_pkg;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [1:0] ST_BAD_SPAN = 2'd2;

  localparam logic REG_FIXED_SLOTS    = 1'b0;
  localparam logic REG_WIDTH_IS_FIXED = 1'b1;

  localparam logic [4:0] FIXED_SLOTS_RESET = 5'd2;

  typedef struct packed {
    logic       action;
    logic [6:0] row_span;
    logic [6:0] column_span;
  } request_t;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] column;
    logic [1:0] status;
  } result_t;

endpackage

// ===== hdl/grid_first_fit_rect_allocator_core.sv =====
// Top level: first-fit rectangle allocator over a line-per-word occupancy map.
`timescale 1ns / 1ps
// One item at a time. After reset, and on every clear request, the map is swept
// one line per cycle with busy high. A bad span request is answered from the
// check state. An allocate walks candidate lines: for each line it reads the window
// of req_lines words through the single memory read port (a read state and an
// accumulate state per word), then tests slot positions one per cycle with the
// shared shift-and-mask unit; on a hit, each line of the window is marked by a
// read state and a write state.
// The result strobe done is high for exactly one cycle and cannot be held off.
module grid_first_fit_rect_allocator_core #(
  parameter int FIXED_MAX = 16,
  parameter int LINES     = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  gffra_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output gffra_pkg::result_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data
);
  import gffra_pkg::*;

  localparam int LW = $clog2(LINES);
  localparam int SW = $clog2(LINES + 128);
  localparam int FW = $clog2(FIXED_MAX + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_LINE  = 9'b000001000,
    S_RD    = 9'b000010000,
    S_ACC   = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_MRD   = 9'b010000000,
    S_MWR   = 9'b100000000
  } state_t;

  state_t               state;
  logic [4:0]           fixed_slots;
  logic                 width_is_fixed;
  logic [LW-1:0]        clr_idx;
  logic                 clr_reply;
  logic [SW-1:0]        line;
  logic [6:0]           k;
  logic [6:0]           rl;
  logic [6:0]           rf_raw;
  logic [FW-1:0]        rf;
  logic [FW-1:0]        slot;
  logic [FIXED_MAX-1:0] acc;
  logic [FIXED_MAX-1:0] rdata;
  logic [FIXED_MAX-1:0] mem [LINES];

  logic [FW-1:0]        slots;
  logic [FIXED_MAX-1:0] run_mask;
  logic                 window_free;
  logic [SW-1:0]        addr_sum;
  logic [LW-1:0]        mem_addr;
  logic                 mem_we;
  logic [LW-1:0]        mem_waddr;
  logic [FIXED_MAX-1:0] mem_wdata;
  logic                 last_k;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy && !start;

  always_comb begin
    if (fixed_slots == 5'd0) begin
      slots = FW'(1);
    end else if (int'(fixed_slots) > FIXED_MAX) begin
      slots = FW'(FIXED_MAX);
    end else begin
      slots = FW'(fixed_slots);
    end
  end

  assign run_mask    = ~({FIXED_MAX{1'b1}} << rf);
  assign window_free = (((acc >> slot) & run_mask) == '0);
  assign addr_sum    = line + SW'(k);
  assign mem_addr    = addr_sum[LW-1:0];
  assign last_k      = (k == rl - 7'd1);

  assign mem_we    = (state == S_CLEAR) || (state == S_MWR);
  assign mem_waddr = (state == S_CLEAR) ? clr_idx : mem_addr;
  assign mem_wdata = (state == S_CLEAR) ? '0 : (rdata | (run_mask << slot));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_slots    <= FIXED_SLOTS_RESET;
      width_is_fixed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIXED_SLOTS:    fixed_slots    <= cfg_data;
        REG_WIDTH_IS_FIXED: width_is_fixed <= cfg_data[0];
        default:            fixed_slots    <= fixed_slots;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      clr_reply <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (request.action == ACT_CLEAR) begin
              clr_idx   <= '0;
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end else begin
              rf_raw <= width_is_fixed ? request.column_span : request.row_span;
              rl     <= width_is_fixed ? request.row_span : request.column_span;
              state  <= S_CHECK;
            end
          end
        end
        S_CLEAR: begin
          if (clr_idx == LW'(LINES - 1)) begin
            state <= S_IDLE;
            if (clr_reply) begin
              done   <= 1'b1;
              result <= '{row: 6'd0, column: 6'd0, status: ST_DONE};
            end
          end else begin
            clr_idx <= clr_idx + LW'(1);
          end
        end
        S_CHECK: begin
          if (rf_raw == 7'd0 || rl == 7'd0 || 8'(rf_raw) > 8'(slots)) begin
            done   <= 1'b1;
            result <= '{row: 6'd0, column: 6'd0, status: ST_BAD_SPAN};
            state  <= S_IDLE;
          end else begin
            rf    <= FW'(rf_raw);
            line  <= '0;
            state <= S_LINE;
          end
        end
        S_LINE: begin
          if (line + SW'(rl) > SW'(LINES)) begin
            done   <= 1'b1;
            result <= '{row: 6'd0, column: 6'd0, status: ST_NO_ROOM};
            state  <= S_IDLE;
          end else begin
            k     <= '0;
            acc   <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc | rdata;
          if (last_k) begin
            slot  <= '0;
            state <= S_SCAN;
          end else begin
            k     <= k + 7'd1;
            state <= S_RD;
          end
        end
        S_SCAN: begin
          if ((FW+1)'(slot) + (FW+1)'(rf) > (FW+1)'(slots)) begin
            line  <= line + SW'(1);
            state <= S_LINE;
          end else if (window_free) begin
            k     <= '0;
            state <= S_MRD;
          end else begin
            slot <= slot + FW'(1);
          end
        end
        S_MRD: begin
          state <= S_MWR;
        end
        S_MWR: begin
          if (last_k) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (width_is_fixed) begin
              result <= '{row: line[5:0], column: 6'(slot), status: ST_DONE};
            end else begin
              result <= '{row: 6'(slot), column: line[5:0], status: ST_DONE};
            end
          end else begin
            k     <= k + 7'd1;
            state <= S_MRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/gffra_checker.sv =====
// Checker: port-level properties of the rectangle allocator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gffra_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input gffra_pkg::result_t result
);
  import gffra_pkg::*;

  logic failed_reply;

  assign failed_reply = done && (result.status != ST_DONE);

  `ASSERT_IMPLIES(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPLIES(a_status_code, clk, rst, done, result.status <= ST_BAD_SPAN)
  `ASSERT_IMPLIES(a_fail_zero, clk, rst, failed_reply, result.row == 6'd0 && result.column == 6'd0)

endmodule

bind grid_first_fit_rect_allocator_core gffra_checker u_gffra_checker (.*);
